// ----- rtl/core/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, codes and widths for the frustum cull tester: transaction
// payloads, operation and visibility codes, sequencer states and step codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  // table geometry
  localparam int unsigned PLANE_COUNT   = 6;
  localparam int unsigned DIST_PLANES   = 5;
  localparam int unsigned BOX_CORNERS   = 8;
  localparam int unsigned COEFS         = 4;
  localparam int unsigned FRACTION_BITS = 16;

  // datapath widths
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RADIUS_W    = 31;
  localparam int unsigned PROD_W      = 2 * WORD_W;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned DIST_W      = ACC_W - FRACTION_BITS + 1;
  localparam int unsigned PLANE_IDX_W = 3;
  localparam int unsigned COEF_IDX_W  = $clog2(COEFS);
  localparam int unsigned CORNER_W    = $clog2(BOX_CORNERS);
  localparam int unsigned STEP_W      = 3;

  // operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BOX    = 2'd1,
    OP_SPHERE = 2'd2,
    OP_DIST   = 2'd3
  } fct_op_e;

  // visibility codes
  typedef enum logic [1:0] {
    VIS_FULL    = 2'd0,
    VIS_PARTIAL = 2'd1,
    VIS_NONE    = 2'd2
  } fct_vis_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } fct_state_e;

  // steps of one plane evaluation
  localparam logic [STEP_W-1:0] STEP_MUL_X  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_Y  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_Z  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ACC_Z  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_OFFSET = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EVAL   = 3'd5;

  // coefficient slots within a plane
  localparam logic [COEF_IDX_W-1:0] COEF_NX  = 2'd0;
  localparam logic [COEF_IDX_W-1:0] COEF_NY  = 2'd1;
  localparam logic [COEF_IDX_W-1:0] COEF_NZ  = 2'd2;
  localparam logic [COEF_IDX_W-1:0] COEF_OFS = 2'd3;

  // input transaction
  typedef struct packed {
    fct_op_e                   op;
    logic [PLANE_IDX_W-1:0]    plane_index;
    logic signed [WORD_W-1:0]  first_x;
    logic signed [WORD_W-1:0]  first_y;
    logic signed [WORD_W-1:0]  first_z;
    logic signed [WORD_W-1:0]  second_x;
    logic signed [WORD_W-1:0]  second_y;
    logic signed [WORD_W-1:0]  second_z;
    logic signed [WORD_W-1:0]  plane_offset;
    logic [RADIUS_W-1:0]       radius;
  } fct_in_t;

  // result transaction
  typedef struct packed {
    fct_vis_e                  visibility;
    logic signed [WORD_W-1:0]  distance;
  } fct_out_t;

  // sequencer control toward the plane store and the mac unit
  typedef struct packed {
    logic [STEP_W-1:0]      step;
    logic [PLANE_IDX_W-1:0] plane;
    logic [CORNER_W-1:0]    corner;
    logic [COEF_IDX_W-1:0]  coef;
  } fct_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/frustum_cull_tester_core.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_tester_core
// Clip plane table with box, sphere and distance visibility tests in Q16.16.
//
// A plane write (op 0) goes straight into the table and produces no result;
// the block is ready again at once. Every test is worked through one shared
// 32x32 multiply-accumulate unit that takes each plane evaluation through
// its steps (three products, final sum, scale and offset, decision), so a
// box test evaluates 6 planes at each of 8 corners, a sphere partial test
// up to 6 planes and a distance test up to 5 planes, fewer when an early
// plane culls; the result is then handed to the output register.
// Input stall stays high from the accepted test until its result moves into
// the output register; a new transaction is accepted while that register
// still waits for the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_tester_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fct_pkg::fct_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fct_pkg::fct_out_t   out_data_o
);

  fct_pkg::fct_in_t                    item_q;
  fct_pkg::fct_ctrl_t                  ctrl;
  fct_pkg::fct_out_t                   result;
  fct_pkg::fct_out_t                   out_data_q;
  logic                                out_valid_q, out_valid_d;
  logic                                in_accept;
  logic                                wr_en;
  logic                                start;
  logic                                busy;
  logic                                done;
  logic                                out_free;
  logic                                out_load;
  logic signed [fct_pkg::WORD_W-1:0]   coef;
  logic signed [fct_pkg::DIST_W-1:0]   plane_dist;

  // input transaction decode
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = in_accept && (in_data_i.op == fct_pkg::OP_WRITE)
                   && (in_data_i.plane_index < fct_pkg::PLANE_IDX_W'(fct_pkg::PLANE_COUNT));
  assign start      = in_accept && (in_data_i.op != fct_pkg::OP_WRITE);

  // captured test operands
  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q <= in_data_i;
    end
  end

  fct_plane_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_plane_i (in_data_i.plane_index),
    .wr_nx_i    (in_data_i.first_x),
    .wr_ny_i    (in_data_i.first_y),
    .wr_nz_i    (in_data_i.first_z),
    .wr_ofs_i   (in_data_i.plane_offset),
    .rd_plane_i (ctrl.plane),
    .rd_coef_i  (ctrl.coef),
    .rd_data_o  (coef)
  );

  fct_mac_unit u_mac (
    .clk_i  (clk_i),
    .item_i (item_q),
    .ctrl_i (ctrl),
    .coef_i (coef),
    .dist_o (plane_dist)
  );

  fct_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_i       (item_q.op),
    .radius_i   (item_q.radius),
    .dist_i     (plane_dist),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy),
    .done_o     (done),
    .result_o   (result)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = done && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/fct_plane_store.sv -----
// ----------------------------------------------------------------------------
// fct_plane_store
// Clip plane table: normal and offset words for each plane, cleared at reset,
// written as a whole plane, read one coefficient at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_plane_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [fct_pkg::PLANE_IDX_W-1:0]        wr_plane_i,
  input  logic signed [fct_pkg::WORD_W-1:0]      wr_nx_i,
  input  logic signed [fct_pkg::WORD_W-1:0]      wr_ny_i,
  input  logic signed [fct_pkg::WORD_W-1:0]      wr_nz_i,
  input  logic signed [fct_pkg::WORD_W-1:0]      wr_ofs_i,
  input  logic [fct_pkg::PLANE_IDX_W-1:0]        rd_plane_i,
  input  logic [fct_pkg::COEF_IDX_W-1:0]         rd_coef_i,
  output logic signed [fct_pkg::WORD_W-1:0]      rd_data_o
);

  logic signed [fct_pkg::WORD_W-1:0] coef_q [fct_pkg::PLANE_COUNT][fct_pkg::COEFS];

  // plane write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < fct_pkg::PLANE_COUNT; p++) begin
        for (int c = 0; c < fct_pkg::COEFS; c++) begin
          coef_q[p][c] <= '0;
        end
      end
    end else if (wr_en_i) begin
      coef_q[wr_plane_i][fct_pkg::COEF_NX]  <= wr_nx_i;
      coef_q[wr_plane_i][fct_pkg::COEF_NY]  <= wr_ny_i;
      coef_q[wr_plane_i][fct_pkg::COEF_NZ]  <= wr_nz_i;
      coef_q[wr_plane_i][fct_pkg::COEF_OFS] <= wr_ofs_i;
    end
  end

  // coefficient read for the current step
  assign rd_data_o = coef_q[rd_plane_i][rd_coef_i];

endmodule

`default_nettype wire

// ----- rtl/core/fct_mac_unit.sv -----
// ----------------------------------------------------------------------------
// fct_mac_unit
// Shared multiply-accumulate unit: one 32x32 product per cycle, summed over
// the three normal terms, then scaled and offset into a plane value.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_mac_unit (
  input  logic                                 clk_i,
  input  fct_pkg::fct_in_t                     item_i,
  input  fct_pkg::fct_ctrl_t                   ctrl_i,
  input  logic signed [fct_pkg::WORD_W-1:0]    coef_i,
  output logic signed [fct_pkg::DIST_W-1:0]    dist_o
);

  logic signed [fct_pkg::WORD_W-1:0] pt_x, pt_y, pt_z;
  logic signed [fct_pkg::WORD_W-1:0] operand;
  logic signed [fct_pkg::PROD_W-1:0] product;
  logic signed [fct_pkg::PROD_W-1:0] prod_q;
  logic signed [fct_pkg::ACC_W-1:0]  acc_q;
  logic signed [fct_pkg::DIST_W-1:0] dist_q;

  // box corner selection, corner zero is the first point
  assign pt_x = ctrl_i.corner[0] ? item_i.second_x : item_i.first_x;
  assign pt_y = ctrl_i.corner[1] ? item_i.second_y : item_i.first_y;
  assign pt_z = ctrl_i.corner[2] ? item_i.second_z : item_i.first_z;

  // operand for the current step
  always_comb begin
    case (ctrl_i.step)
      fct_pkg::STEP_MUL_X: operand = pt_x;
      fct_pkg::STEP_MUL_Y: operand = pt_y;
      default:             operand = pt_z;
    endcase
  end

  assign product = coef_i * operand;

  // product register, accumulator and plane value
  always_ff @(posedge clk_i) begin
    prod_q <= product;
    case (ctrl_i.step) inside
      fct_pkg::STEP_MUL_X: begin
        acc_q <= '0;
      end
      fct_pkg::STEP_MUL_Y, fct_pkg::STEP_MUL_Z, fct_pkg::STEP_ACC_Z: begin
        acc_q <= acc_q + fct_pkg::ACC_W'(prod_q);
      end
      fct_pkg::STEP_OFFSET: begin
        dist_q <= fct_pkg::DIST_W'(acc_q >>> fct_pkg::FRACTION_BITS)
                + fct_pkg::DIST_W'(coef_i);
      end
      default: begin
      end
    endcase
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ----- rtl/core/fct_sequencer.sv -----
// ----------------------------------------------------------------------------
// fct_sequencer
// Step, plane and corner sequencing for the visibility tests, with the
// per-plane decision logic and the verdict registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  fct_pkg::fct_op_e                     op_i,
  input  logic [fct_pkg::RADIUS_W-1:0]         radius_i,
  input  logic signed [fct_pkg::DIST_W-1:0]    dist_i,
  input  logic                                 out_free_i,
  output fct_pkg::fct_ctrl_t                   ctrl_o,
  output logic                                 busy_o,
  output logic                                 done_o,
  output fct_pkg::fct_out_t                    result_o
);

  localparam logic [fct_pkg::CORNER_W-1:0] CornerLast =
    fct_pkg::CORNER_W'(fct_pkg::BOX_CORNERS - 1);
  localparam logic [fct_pkg::PLANE_IDX_W-1:0] PlaneLastAll =
    fct_pkg::PLANE_IDX_W'(fct_pkg::PLANE_COUNT - 1);
  localparam logic [fct_pkg::PLANE_IDX_W-1:0] PlaneLastDist =
    fct_pkg::PLANE_IDX_W'(fct_pkg::DIST_PLANES - 1);

  fct_pkg::fct_state_e                   state_q, state_d;
  logic [fct_pkg::STEP_W-1:0]            step_q, step_d;
  logic [fct_pkg::PLANE_IDX_W-1:0]       plane_q, plane_d;
  logic [fct_pkg::CORNER_W-1:0]          corner_q, corner_d;
  logic                                  any_out_q, any_out_d;
  logic [fct_pkg::PLANE_COUNT-1:0]       all_out_q, all_out_d;
  fct_pkg::fct_vis_e                     vis_q, vis_d;
  logic signed [fct_pkg::WORD_W-1:0]     dist_res_q, dist_res_d;

  logic                                  finish;
  logic                                  eval;
  logic                                  last_plane;
  logic                                  neg;
  logic                                  le_neg_r;
  logic                                  le_r;
  logic                                  fits;
  logic signed [fct_pkg::DIST_W:0]       dist_ext, r_ext, sum_r, diff_r;
  logic signed [fct_pkg::WORD_W-1:0]     dist_sat;

  // plane value compares against zero and the radius
  assign dist_ext = (fct_pkg::DIST_W + 1)'(dist_i);
  assign r_ext    = $signed((fct_pkg::DIST_W + 1)'({1'b0, radius_i}));
  assign sum_r    = dist_ext + r_ext;
  assign diff_r   = dist_ext - r_ext;
  assign neg      = dist_i[fct_pkg::DIST_W-1];
  assign le_neg_r = sum_r[fct_pkg::DIST_W] || (sum_r == '0);
  assign le_r     = diff_r[fct_pkg::DIST_W] || (diff_r == '0);

  // saturation to 32 bits
  assign fits = (&dist_i[fct_pkg::DIST_W-1:fct_pkg::WORD_W-1])
             || (~|dist_i[fct_pkg::DIST_W-1:fct_pkg::WORD_W-1]);
  assign dist_sat = fits ? dist_i[fct_pkg::WORD_W-1:0]
                  : neg  ? $signed({1'b1, {(fct_pkg::WORD_W-1){1'b0}}})
                         : $signed({1'b0, {(fct_pkg::WORD_W-1){1'b1}}});

  assign eval       = (state_q == fct_pkg::ST_RUN) && (step_q == fct_pkg::STEP_EVAL);
  assign last_plane = (op_i == fct_pkg::OP_DIST) ? (plane_q == PlaneLastDist)
                                                 : (plane_q == PlaneLastAll);

  // counters and verdict update
  always_comb begin
    step_d     = step_q;
    plane_d    = plane_q;
    corner_d   = corner_q;
    any_out_d  = any_out_q;
    all_out_d  = all_out_q;
    vis_d      = vis_q;
    dist_res_d = dist_res_q;
    finish     = 1'b0;
    if (start_i) begin
      step_d     = fct_pkg::STEP_MUL_X;
      plane_d    = '0;
      corner_d   = '0;
      any_out_d  = 1'b0;
      all_out_d  = '1;
      vis_d      = fct_pkg::VIS_FULL;
      dist_res_d = '0;
    end else if (state_q == fct_pkg::ST_RUN) begin
      if (!eval) begin
        step_d = step_q + 1'b1;
      end else begin
        step_d = fct_pkg::STEP_MUL_X;
        unique case (op_i)
          fct_pkg::OP_BOX: begin
            any_out_d          = any_out_q | neg;
            all_out_d[plane_q] = all_out_q[plane_q] & neg;
            finish             = last_plane && (corner_q == CornerLast);
            vis_d = !any_out_d   ? fct_pkg::VIS_FULL
                  : |all_out_d   ? fct_pkg::VIS_NONE
                                 : fct_pkg::VIS_PARTIAL;
          end
          fct_pkg::OP_SPHERE: begin
            if (le_neg_r) begin
              vis_d  = fct_pkg::VIS_NONE;
              finish = 1'b1;
            end else begin
              if (le_r) begin
                vis_d = fct_pkg::VIS_PARTIAL;
              end
              finish = last_plane;
            end
          end
          fct_pkg::OP_DIST: begin
            if (neg && le_neg_r) begin
              vis_d      = fct_pkg::VIS_NONE;
              dist_res_d = '0;
              finish     = 1'b1;
            end else if (last_plane) begin
              dist_res_d = dist_sat;
              finish     = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (last_plane) begin
          plane_d  = '0;
          corner_d = corner_q + 1'b1;
        end else begin
          plane_d = plane_q + 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fct_pkg::ST_IDLE: if (start_i)    state_d = fct_pkg::ST_RUN;
      fct_pkg::ST_RUN:  if (finish)     state_d = fct_pkg::ST_DONE;
      fct_pkg::ST_DONE: if (out_free_i) state_d = fct_pkg::ST_IDLE;
      default:                          state_d = fct_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o   = (state_q != fct_pkg::ST_IDLE);
    done_o   = (state_q == fct_pkg::ST_DONE);
    result_o = '{visibility: vis_q, distance: dist_res_q};
    ctrl_o.step   = step_q;
    ctrl_o.plane  = plane_q;
    ctrl_o.corner = corner_q;
    unique case (step_q)
      fct_pkg::STEP_MUL_X: ctrl_o.coef = fct_pkg::COEF_NX;
      fct_pkg::STEP_MUL_Y: ctrl_o.coef = fct_pkg::COEF_NY;
      fct_pkg::STEP_MUL_Z: ctrl_o.coef = fct_pkg::COEF_NZ;
      default:             ctrl_o.coef = fct_pkg::COEF_OFS;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fct_pkg::ST_IDLE;
      step_q     <= fct_pkg::STEP_MUL_X;
      plane_q    <= '0;
      corner_q   <= '0;
      any_out_q  <= 1'b0;
      all_out_q  <= '1;
      vis_q      <= fct_pkg::VIS_FULL;
      dist_res_q <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      plane_q    <= plane_d;
      corner_q   <= corner_d;
      any_out_q  <= any_out_d;
      all_out_q  <= all_out_d;
      vis_q      <= vis_d;
      dist_res_q <= dist_res_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fct_checker.sv -----
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks for the frustum cull tester, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fct_pkg::fct_in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fct_pkg::fct_out_t  out_data_o
);

  // a test transaction keeps the input side closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.op != fct_pkg::OP_WRITE)) |=> in_stall_o)
    else $error("input taken again right after a test transaction");

  // a plane write never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.op == fct_pkg::OP_WRITE) && !out_valid_o
     && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared after a plane write");

  // only the three visibility codes leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.visibility == fct_pkg::VIS_FULL
                  || out_data_o.visibility == fct_pkg::VIS_PARTIAL
                  || out_data_o.visibility == fct_pkg::VIS_NONE))
    else $error("undefined visibility code");

  // a nonzero distance only comes with an unculled distance result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.distance != '0))
      |-> (out_data_o.visibility == fct_pkg::VIS_FULL))
    else $error("distance reported on a culled or partial result");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind frustum_cull_tester_core fct_checker u_fct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks frustum_cull_tester_core against a cycle-free predictor of the clip
// plane table and of the box, sphere and distance tests. Directed tests cover
// the cleared table, ignored plane slots, each visibility outcome and the
// saturated distance; random traffic follows, with idle bursts on both sides,
// a long output hold and a final stretch without idling.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 320;
  localparam int HOLD_CYCLES   = 700;
  localparam int ONE           = 65536;
  localparam int WIDE_W        = 68;

  typedef logic signed [fct_pkg::WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t WORD_MAX = 68'sd2147483647;
  localparam wide_t WORD_MIN = -68'sd2147483648;

  // clock, reset and handshake signals
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  fct_pkg::fct_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fct_pkg::fct_out_t out_data;

  // testbench state
  word_t             clip_planes [fct_pkg::PLANE_COUNT][fct_pkg::COEFS];
  fct_pkg::fct_out_t expected_results [$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                hold_cycles = 0;
  int                stall_burst = 0;
  bit                send_idle   = 1'b0;
  bit                recv_idle   = 1'b0;

  frustum_cull_tester_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // plane value: floor of the dot product over the fraction bits plus offset
  function automatic wide_t plane_distance(int p, word_t x, word_t y, word_t z);
    wide_t nx, ny, nz, ofs, wx, wy, wz, acc;
    nx  = clip_planes[p][fct_pkg::COEF_NX];
    ny  = clip_planes[p][fct_pkg::COEF_NY];
    nz  = clip_planes[p][fct_pkg::COEF_NZ];
    ofs = clip_planes[p][fct_pkg::COEF_OFS];
    wx  = x;
    wy  = y;
    wz  = z;
    acc = nx * wx + ny * wy + nz * wz;
    return (acc >>> fct_pkg::FRACTION_BITS) + ofs;
  endfunction

  // visibility and distance of one test transaction
  function automatic fct_pkg::fct_out_t cull_result(fct_pkg::fct_in_t t);
    fct_pkg::fct_out_t               res;
    logic [fct_pkg::PLANE_COUNT-1:0] or_code, and_code, code;
    wide_t                           d, r;
    word_t                           x, y, z;
    bit                              culled;
    res.visibility = fct_pkg::VIS_FULL;
    res.distance   = '0;
    r = {37'd0, t.radius};
    case (t.op)
      fct_pkg::OP_BOX: begin
        or_code  = '0;
        and_code = '1;
        for (int k = 0; k < fct_pkg::BOX_CORNERS; k++) begin
          x = (k & 1) ? t.second_x : t.first_x;
          y = (k & 2) ? t.second_y : t.first_y;
          z = (k & 4) ? t.second_z : t.first_z;
          code = '0;
          for (int p = 0; p < fct_pkg::PLANE_COUNT; p++) begin
            if (plane_distance(p, x, y, z) < 0) code[p] = 1'b1;
          end
          or_code  |= code;
          and_code &= code;
        end
        if (or_code == '0) res.visibility = fct_pkg::VIS_FULL;
        else if (and_code != '0) res.visibility = fct_pkg::VIS_NONE;
        else res.visibility = fct_pkg::VIS_PARTIAL;
      end
      fct_pkg::OP_SPHERE: begin
        for (int p = 0; p < fct_pkg::PLANE_COUNT; p++) begin
          d = plane_distance(p, t.first_x, t.first_y, t.first_z);
          if (d <= -r) begin
            res.visibility = fct_pkg::VIS_NONE;
            break;
          end else if (d <= r) begin
            res.visibility = fct_pkg::VIS_PARTIAL;
          end
        end
      end
      fct_pkg::OP_DIST: begin
        culled = 1'b0;
        d      = '0;
        for (int p = 0; p < fct_pkg::DIST_PLANES; p++) begin
          d = plane_distance(p, t.first_x, t.first_y, t.first_z);
          if (d < 0 && d <= -r) begin
            culled = 1'b1;
            break;
          end
        end
        // last plane value, clamped to the word range
        if (culled) res.visibility = fct_pkg::VIS_NONE;
        else if (d > WORD_MAX) res.distance = WORD_MAX[fct_pkg::WORD_W-1:0];
        else if (d < WORD_MIN) res.distance = WORD_MIN[fct_pkg::WORD_W-1:0];
        else res.distance = d[fct_pkg::WORD_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // apply an accepted transaction to the plane table or queue its result
  function automatic void track_transaction(fct_pkg::fct_in_t t);
    if (t.op == fct_pkg::OP_WRITE) begin
      if (t.plane_index < fct_pkg::PLANE_COUNT) begin
        clip_planes[t.plane_index][fct_pkg::COEF_NX]  = t.first_x;
        clip_planes[t.plane_index][fct_pkg::COEF_NY]  = t.first_y;
        clip_planes[t.plane_index][fct_pkg::COEF_NZ]  = t.first_z;
        clip_planes[t.plane_index][fct_pkg::COEF_OFS] = t.plane_offset;
      end
    end else begin
      expected_results.push_back(cull_result(t));
    end
  endfunction

  function automatic word_t rand_span(int lo, int hi);
    return lo + $urandom_range(0, hi - lo);
  endfunction

  // every field random, so unused fields toggle too
  function automatic fct_pkg::fct_in_t noise_item();
    fct_pkg::fct_in_t t;
    t.op           = fct_pkg::fct_op_e'($urandom_range(0, 3));
    t.plane_index  = fct_pkg::PLANE_IDX_W'($urandom_range(0, 7));
    t.first_x      = $urandom;
    t.first_y      = $urandom;
    t.first_z      = $urandom;
    t.second_x     = $urandom;
    t.second_y     = $urandom;
    t.second_z     = $urandom;
    t.plane_offset = $urandom;
    t.radius       = 31'($urandom);
    return t;
  endfunction

  function automatic fct_pkg::fct_in_t random_item();
    fct_pkg::fct_in_t t;
    int unsigned      sel;
    t   = noise_item();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      t.op = fct_pkg::OP_WRITE;
    end else if (sel < 16) begin
      t.op           = fct_pkg::OP_WRITE;
      t.plane_index  = fct_pkg::PLANE_IDX_W'($urandom_range(0, fct_pkg::PLANE_COUNT - 1));
      t.first_x      = rand_span(-ONE, ONE);
      t.first_y      = rand_span(-ONE, ONE);
      t.first_z      = rand_span(-ONE, ONE);
      t.plane_offset = rand_span(-16 * ONE, 64 * ONE);
    end else if (sel < 48) begin
      t.op = fct_pkg::OP_BOX;
      if (sel < 40) begin
        t.first_x  = rand_span(-128 * ONE, 128 * ONE);
        t.first_y  = rand_span(-128 * ONE, 128 * ONE);
        t.first_z  = rand_span(-128 * ONE, 128 * ONE);
        t.second_x = t.first_x + rand_span(0, 32 * ONE);
        t.second_y = t.first_y + rand_span(0, 32 * ONE);
        t.second_z = t.first_z + rand_span(0, 32 * ONE);
        // occasionally a min corner above the max corner
        if ($urandom_range(0, 9) == 0) t.second_x = t.first_x - rand_span(1, 16 * ONE);
      end
    end else begin
      t.op = ($urandom_range(0, 1) == 0) ? fct_pkg::OP_SPHERE : fct_pkg::OP_DIST;
      if (sel < 92) begin
        t.first_x = rand_span(-128 * ONE, 128 * ONE);
        t.first_y = rand_span(-128 * ONE, 128 * ONE);
        t.first_z = rand_span(-128 * ONE, 128 * ONE);
        t.radius  = ($urandom_range(0, 7) == 0) ? '0 : 31'($urandom_range(0, 40 * ONE));
      end
    end
    return t;
  endfunction

  // report one mismatch and count it
  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  // offer one transaction and wait for it to be taken
  task automatic send_item(fct_pkg::fct_in_t t);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    track_transaction(t);
  endtask

  task automatic write_plane(int idx, word_t nx, word_t ny, word_t nz, word_t ofs);
    fct_pkg::fct_in_t t;
    t              = noise_item();
    t.op           = fct_pkg::OP_WRITE;
    t.plane_index  = fct_pkg::PLANE_IDX_W'(idx);
    t.first_x      = nx;
    t.first_y      = ny;
    t.first_z      = nz;
    t.plane_offset = ofs;
    send_item(t);
  endtask

  task automatic send_box(word_t x0, word_t y0, word_t z0, word_t x1, word_t y1, word_t z1);
    fct_pkg::fct_in_t t;
    t          = noise_item();
    t.op       = fct_pkg::OP_BOX;
    t.first_x  = x0;
    t.first_y  = y0;
    t.first_z  = z0;
    t.second_x = x1;
    t.second_y = y1;
    t.second_z = z1;
    send_item(t);
  endtask

  task automatic send_sphere(fct_pkg::fct_op_e op, word_t cx, word_t cy, word_t cz,
                             logic [fct_pkg::RADIUS_W-1:0] r);
    fct_pkg::fct_in_t t;
    t         = noise_item();
    t.op      = op;
    t.first_x = cx;
    t.first_y = cy;
    t.first_z = cz;
    t.radius  = r;
    send_item(t);
  endtask

  // drop valid and wait until every queued result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_random_frustum();
    for (int p = 0; p < fct_pkg::PLANE_COUNT; p++) begin
      write_plane(p, rand_span(-ONE, ONE), rand_span(-ONE, ONE), rand_span(-ONE, ONE),
                  rand_span(8 * ONE, 64 * ONE));
    end
  endtask

  // all planes zero after reset: every plane value is zero
  task automatic test_cleared_table();
    send_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_sphere(fct_pkg::OP_SPHERE, 0, 0, 0, '0);
    send_sphere(fct_pkg::OP_SPHERE, 0, 0, 0, '1);
    send_sphere(fct_pkg::OP_DIST, 0, 0, 0, '0);
  endtask

  // writes to slots past the table are dropped
  task automatic test_plane_slots();
    write_plane(6, -ONE, -ONE, -ONE, -ONE);
    write_plane(7, -ONE, -ONE, -ONE, 32'sh8000_0000);
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    wait_for_results();
  endtask

  // axis aligned cube of half size 10: inside, straddling, outside, inverted
  task automatic test_box_cases();
    write_plane(0,  ONE, 0, 0, 10 * ONE);
    write_plane(1, -ONE, 0, 0, 10 * ONE);
    write_plane(2, 0,  ONE, 0, 10 * ONE);
    write_plane(3, 0, -ONE, 0, 10 * ONE);
    write_plane(4, 0, 0,  ONE, 10 * ONE);
    write_plane(5, 0, 0, -ONE, 10 * ONE);
    send_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_box(5 * ONE, 0, 0, 15 * ONE, ONE, ONE);
    send_box(20 * ONE, 0, 0, 30 * ONE, ONE, ONE);
    send_box(15 * ONE, ONE, ONE, -15 * ONE, -ONE, -ONE);
  endtask

  // sphere inside, touching a plane, culled, and distance to plane 4
  task automatic test_sphere_cases();
    send_sphere(fct_pkg::OP_SPHERE, 0, 0, 0, 31'(ONE));
    send_sphere(fct_pkg::OP_SPHERE, 0, 0, 0, 31'(10 * ONE));
    send_sphere(fct_pkg::OP_SPHERE, 12 * ONE, 0, 0, 31'(2 * ONE));
    send_sphere(fct_pkg::OP_DIST, 12 * ONE, 0, 0, 31'(2 * ONE));
    send_sphere(fct_pkg::OP_DIST, 3 * ONE, 0, 0, '0);
    wait_for_results();
  endtask

  // huge plane 4 value saturates; plane 5 only affects the partial test
  task automatic test_distance_saturation();
    write_plane(4, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000);
    write_plane(5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    send_sphere(fct_pkg::OP_DIST, 0, 0, 32'sh7fff_ffff, '0);
    send_sphere(fct_pkg::OP_SPHERE, 0, 0, 32'sh7fff_ffff, '0);
    wait_for_results();
  endtask

  // receiver holds off while tests keep coming, so the core backs up
  task automatic test_output_hold();
    fct_pkg::fct_in_t t;
    send_idle = 1'b0;
    recv_idle <= 1'b0;
    load_random_frustum();
    hold_cycles <= HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      t = random_item();
      if (t.op == fct_pkg::OP_WRITE) t.op = fct_pkg::OP_SPHERE;
      send_item(t);
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count, bit idle);
    send_idle = idle;
    recv_idle <= idle;
    load_random_frustum();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) load_random_frustum();
      send_item(random_item());
    end
    wait_for_results();
  endtask

  // downstream stall: long holds and random bursts
  always @(posedge clk) begin : receiver
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_burst > 0) begin
      out_stall   <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      out_stall   <= 1'b1;
      stall_burst <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    fct_pkg::fct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result vis %0d dist %0d",
                                  out_data.visibility, out_data.distance));
      end else begin
        want = expected_results.pop_front();
        if (out_data.visibility !== want.visibility)
          report_mismatch($sformatf("visibility %0d, expected %0d",
                                    out_data.visibility, want.visibility));
        if (out_data.distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    out_data.distance, want.distance));
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main
    foreach (clip_planes[p, c]) clip_planes[p][c] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_table();
    test_plane_slots();
    test_box_cases();
    test_sphere_cases();
    test_distance_saturation();
    test_output_hold();
    test_random_traffic(800, 1'b1);
    test_random_traffic(150, 1'b0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fct_pkg.sv
rtl/core/fct_plane_store.sv
rtl/core/fct_mac_unit.sv
rtl/core/fct_sequencer.sv
rtl/core/frustum_cull_tester_core.sv
rtl/core/fct_checker.sv
verif/tb_top.sv
